[rtl/core/hlh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlh_pkg
// Shared types, codes and constants for the IPv6 hop-limit histogram unit.
// ----------------------------------------------------------------------------
package hlh_pkg;

  // default configuration
  localparam int DEF_VLAN_DEPTH  = 2;
  localparam int DEF_BIN_BITS    = 8;
  localparam int DEF_COUNT_WIDTH = 32;

  // frame layout
  localparam logic [7:0] ETH_HDR_LEN = 8'd14;
  localparam logic [7:0] IP6_HDR_LEN = 8'd40;
  localparam logic [7:0] HOP_POS     = 8'd7;
  localparam logic [7:0] TAG_LEN     = 8'd4;
  localparam logic [7:0] OFFSET_MAX  = 8'd255;

  // ethertypes
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
  localparam logic [15:0] ETYPE_QTAG  = 16'h8100;
  localparam logic [15:0] ETYPE_ADTAG = 16'h88A8;

  // operation codes of the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic {
    REPLY_FRAME = 1'b0,
    REPLY_READ  = 1'b1
  } reply_kind_t;

  // request from the parser to the counter bank
  typedef struct packed {
    logic        valid;
    reply_kind_t kind;
    logic        counted;
    logic [7:0]  bin;
  } bank_req_t;

  // finished result from the counter bank
  typedef struct packed {
    reply_kind_t kind;
    logic        counted;
    logic [7:0]  bin_number;
    logic [31:0] bin_count;
  } bank_rsp_t;

  function automatic logic is_tag(input logic [15:0] et);
    return (et == ETYPE_QTAG) || (et == ETYPE_ADTAG);
  endfunction

endpackage

[rtl/core/hlh_frame_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlh_frame_parser
// Per-byte frame tracking: ethertype, vlan tag skipping, hop limit capture
// and the end-of-frame decision.
// ----------------------------------------------------------------------------
module hlh_frame_parser #(
  parameter int VLAN_DEPTH = hlh_pkg::DEF_VLAN_DEPTH,
  parameter int BIN_BITS   = hlh_pkg::DEF_BIN_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_operation,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic [7:0]        in_bin_index,
  output hlh_pkg::bank_req_t req_o
);
  import hlh_pkg::*;

  logic [7:0]  off_r, off_nxt;
  logic [15:0] et_r, et_nxt;
  logic [3:0]  tags_r, tags_nxt;
  logic [7:0]  hs_r, hs_nxt;
  logic [7:0]  hop_r, hop_nxt;
  logic [7:0]  prev_r;

  logic       is_read;
  logic [8:0] ip6_end;
  logic       ok;
  logic [7:0] frame_bin;
  logic [7:0] read_bin;

  always_comb begin
    is_read  = (in_operation == OP_READ);
    et_nxt   = et_r;
    hs_nxt   = hs_r;
    tags_nxt = tags_r;
    hop_nxt  = hop_r;
    if (off_r == ETH_HDR_LEN - 8'd1) begin
      et_nxt = {prev_r, in_data_byte};
    end else if (({1'b0, off_r} == {1'b0, hs_r} + {1'b0, TAG_LEN - 8'd1}) &&
                 (off_r >= ETH_HDR_LEN) && is_tag(et_r) &&
                 (tags_r < 4'(VLAN_DEPTH))) begin
      et_nxt   = {prev_r, in_data_byte};
      hs_nxt   = hs_r + TAG_LEN;
      tags_nxt = tags_r + 4'd1;
    end
    if ({1'b0, off_r} == {1'b0, hs_nxt} + {1'b0, HOP_POS}) begin
      hop_nxt = in_data_byte;
    end
    off_nxt = (off_r == OFFSET_MAX) ? off_r : off_r + 8'd1;

    ip6_end   = {1'b0, hs_nxt} + {1'b0, IP6_HDR_LEN - 8'd1};
    ok        = (off_r >= ETH_HDR_LEN - 8'd1) && (et_nxt == ETYPE_IPV6) &&
                ({1'b0, off_r} >= ip6_end);
    // no byte after the header: bin zero
    frame_bin = ({1'b0, off_r} > ip6_end) ? 8'(hop_nxt >> (8 - BIN_BITS)) : 8'd0;
    read_bin  = 8'(in_bin_index[BIN_BITS-1:0]);

    req_o.valid   = in_accept && (is_read || in_last_byte);
    req_o.kind    = is_read ? REPLY_READ : REPLY_FRAME;
    req_o.counted = !is_read && ok;
    req_o.bin     = is_read ? read_bin : (ok ? frame_bin : 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      et_r   <= '0;
      tags_r <= '0;
      hs_r   <= ETH_HDR_LEN;
      hop_r  <= '0;
      prev_r <= '0;
    end else if (in_accept && !is_read) begin
      if (in_last_byte) begin
        off_r  <= '0;
        et_r   <= '0;
        tags_r <= '0;
        hs_r   <= ETH_HDR_LEN;
        hop_r  <= '0;
        prev_r <= '0;
      end else begin
        off_r  <= off_nxt;
        et_r   <= et_nxt;
        tags_r <= tags_nxt;
        hs_r   <= hs_nxt;
        hop_r  <= hop_nxt;
        prev_r <= in_data_byte;
      end
    end
  end

endmodule

[rtl/core/hlh_counter_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlh_counter_bank
// Histogram counter memory with per-bin valid flags, read-modify-write
// stage and forwarding of the bin written on the same edge.
// ----------------------------------------------------------------------------
module hlh_counter_bank #(
  parameter int BIN_BITS    = hlh_pkg::DEF_BIN_BITS,
  parameter int COUNT_WIDTH = hlh_pkg::DEF_COUNT_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hlh_pkg::bank_req_t req_i,
  input  logic               adv_i,
  output logic               s1_valid_o,
  output hlh_pkg::bank_rsp_t rsp_o
);
  import hlh_pkg::*;

  localparam int NUM_BINS = 1 << BIN_BITS;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [NUM_BINS-1:0]    vld_r;

  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [COUNT_WIDTH-1:0] fwd_r;
  logic                   s1_v_r;
  reply_kind_t            s1_kind_r;
  logic                   s1_counted_r;
  logic [BIN_BITS-1:0]    s1_bin_r;
  logic                   s1_hit_r;
  logic                   s1_ent_vld_r;

  logic [BIN_BITS-1:0]    req_bin;
  logic                   wr_en;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] base;
  logic [COUNT_WIDTH-1:0] new_cnt;

  always_comb begin
    req_bin = req_i.bin[BIN_BITS-1:0];
    wr_en   = s1_v_r && s1_counted_r && adv_i;
    hit     = wr_en && (s1_bin_r == req_bin);
    if (s1_hit_r) begin
      base = fwd_r;
    end else if (s1_ent_vld_r) begin
      base = rd_data_r;
    end else begin
      base = '0;
    end
    new_cnt = base + COUNT_WIDTH'(1);

    rsp_o.kind       = s1_kind_r;
    rsp_o.counted    = s1_counted_r;
    rsp_o.bin_number = 8'(s1_bin_r);
    if (s1_counted_r) begin
      rsp_o.bin_count = 32'(new_cnt);
    end else if (s1_kind_r == REPLY_READ) begin
      rsp_o.bin_count = 32'(base);
    end else begin
      rsp_o.bin_count = '0;
    end
  end

  assign s1_valid_o = s1_v_r;

  // counter storage
  always_ff @(posedge clk) begin
    if (req_i.valid) begin
      rd_data_r <= mem[req_bin];
    end
    if (wr_en) begin
      mem[s1_bin_r] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_bin_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (req_i.valid) begin
      s1_v_r <= 1'b1;
    end else if (adv_i) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_r <= new_cnt;
    end
    if (req_i.valid) begin
      s1_kind_r    <= req_i.kind;
      s1_counted_r <= req_i.counted;
      s1_bin_r     <= req_bin;
      s1_hit_r     <= hit;
      s1_ent_vld_r <= vld_r[req_bin];
    end
  end

endmodule

[rtl/core/ipv6_hop_limit_histogram_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_hop_limit_histogram_unit
// Counts IPv6 frames per hop-limit bin and answers bin read requests.
// ----------------------------------------------------------------------------
// Frame bytes stream in one per cycle while in_ready is high (in_operation = 0,
// in_last_byte marks the end); the ethertype is read at bytes 12..13, up to
// VLAN_DEPTH 802.1Q or 802.1AD tags are skipped, and a frame that carries a
// full 40-byte IPv6 header bumps the bin selected by the top BIN_BITS bits
// of its hop limit (bin zero when nothing follows the header). Every final
// byte gives one frame report; every read transaction (in_operation = 1)
// gives one reply with the bin's count. Other bytes give nothing. The unit
// accepts one transaction per clock while in_ready is high; each passes the
// update stage and then an output register, and results sit there, so one
// more transaction is still taken while a result waits. The rate is set by
// the two-port counter memory, which does one read and one write per cycle;
// a bump or read right behind a bump of the same bin is served by forwarding.
// Counters start at zero through per-bin valid flags that reset clears, so
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module ipv6_hop_limit_histogram_unit #(
  parameter int VLAN_DEPTH  = hlh_pkg::DEF_VLAN_DEPTH,
  parameter int BIN_BITS    = hlh_pkg::DEF_BIN_BITS,
  parameter int COUNT_WIDTH = hlh_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_bin_index,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reply_kind,
  output logic        out_counted,
  output logic [7:0]  out_bin_number,
  output logic [31:0] out_bin_count
);
  import hlh_pkg::*;

  logic      in_accept;
  logic      s1_adv;
  logic      s1_valid;
  bank_req_t req;
  bank_rsp_t rsp;

  // output register
  logic        out_v_r;
  reply_kind_t out_kind_r;
  logic        out_counted_r;
  logic [7:0]  out_bin_r;
  logic [31:0] out_count_r;

  // the update stage moves on whenever the output register is free or drains
  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  hlh_frame_parser #(
    .VLAN_DEPTH (VLAN_DEPTH),
    .BIN_BITS   (BIN_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .in_bin_index (in_bin_index),
    .req_o        (req)
  );

  hlh_counter_bank #(
    .BIN_BITS    (BIN_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (req),
    .adv_i      (s1_adv),
    .s1_valid_o (s1_valid),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_valid;
    end
  end

  // payload loads only when a finished transaction moves up
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_kind_r    <= rsp.kind;
      out_counted_r <= rsp.counted;
      out_bin_r     <= rsp.bin_number;
      out_count_r   <= rsp.bin_count;
    end
  end

  assign out_valid      = out_v_r;
  assign out_reply_kind = out_kind_r;
  assign out_counted    = out_counted_r;
  assign out_bin_number = out_bin_r;
  assign out_bin_count  = out_count_r;

  // a full pipeline with a stalled output must hold off new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && out_v_r && !out_ready) |-> !in_ready)
    else $error("input accepted while update stage is blocked");

  // read replies never claim a bin bump
  a_read_not_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == REPLY_READ) |-> !out_counted_r)
    else $error("read reply flagged as counted");

  // ignored frames report bin zero with a zero count
  a_ignored_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_kind_r == REPLY_FRAME && !out_counted_r) |->
      (out_bin_r == 8'd0 && out_count_r == 32'd0))
    else $error("ignored frame reports a nonzero bin or count");

  // reported bin always lies inside the histogram
  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_bin_r >> BIN_BITS) == 8'd0))
    else $error("bin number outside histogram");

endmodule
